### design/ucsw_pkg.sv
// ----------------------------------------------------------------------------
// ucsw_pkg
// Shared types and codes for the unwind code stack walker.
// ----------------------------------------------------------------------------
package ucsw_pkg;

  // action codes
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_SLOT   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // unwind ops
  localparam logic [3:0] OP_PUSH_NONVOL     = 4'd0;
  localparam logic [3:0] OP_ALLOC_LARGE     = 4'd1;
  localparam logic [3:0] OP_ALLOC_SMALL     = 4'd2;
  localparam logic [3:0] OP_SET_FPREG       = 4'd3;
  localparam logic [3:0] OP_SAVE_NONVOL     = 4'd4;
  localparam logic [3:0] OP_SAVE_NONVOL_FAR = 4'd5;
  localparam logic [3:0] OP_SAVE_XMM        = 4'd8;
  localparam logic [3:0] OP_SAVE_XMM_FAR    = 4'd9;
  localparam logic [3:0] OP_MACHFRAME       = 4'd10;

  // operand modes
  localparam logic [1:0] MODE_SKIP   = 2'd0;
  localparam logic [1:0] MODE_SCALED = 2'd1;
  localparam logic [1:0] MODE_RAW    = 2'd2;

  // walk status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_IMPL  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  localparam logic [31:0] SLOT_BYTES        = 32'd8;
  localparam logic [31:0] MACHFRAME_PLAIN   = 32'd40;
  localparam logic [31:0] MACHFRAME_ERRCODE = 32'd48;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] slot_word;
    logic [63:0] start_rsp;
    logic [31:0] func_offset;
  } walk_item_t;

  typedef struct packed {
    logic [63:0] sp;
    logic [31:0] prolog;
    logic [1:0]  slots_left;
    logic [1:0]  mode;
    logic [15:0] low_half;
    logic [1:0]  err;
  } walk_state_t;

  typedef struct packed {
    logic [63:0] return_slot_address;
    logic [63:0] caller_sp;
    logic [1:0]  walk_status;
  } walk_report_t;

endpackage

### design/ucsw_if.sv
// ----------------------------------------------------------------------------
// ucsw_walk_if / ucsw_report_if
// Valid/ready channels for walk items and walk reports.
// ----------------------------------------------------------------------------
interface ucsw_walk_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] slot_word;
  logic [63:0] start_rsp;
  logic [31:0] func_offset;

  modport source (output valid, action, slot_word, start_rsp, func_offset, input ready);
  modport sink   (input valid, action, slot_word, start_rsp, func_offset, output ready);
endinterface

interface ucsw_report_if;
  logic        valid;
  logic        ready;
  logic [63:0] return_slot_address;
  logic [63:0] caller_sp;
  logic [1:0]  walk_status;

  modport source (output valid, return_slot_address, caller_sp, walk_status, input ready);
  modport sink   (input valid, return_slot_address, caller_sp, walk_status, output ready);
endinterface

### design/unwind_code_stack_walker_core.sv
// ----------------------------------------------------------------------------
// unwind_code_stack_walker_core
// Walks x64-style unwind code slots and reports the caller stack frame.
// ----------------------------------------------------------------------------
// Usage:
//   walk   : input channel. A begin transaction loads start_rsp and
//            func_offset; slot transactions carry one 16-bit unwind code
//            slot each; a finish transaction requests a report. Code 3 is
//            dropped.
//   report : output channel, one transaction per finish, carrying the
//            return address slot, the caller rsp and the walk status.
// Timing:
//   Every walk transaction passes through the input stage, where the
//   slot decode and a single 64-bit add update the running stack pointer.
//   A finish report is registered once the finish leaves the input stage.
//   Throughput is one transaction per cycle unless a finish waits on a
//   stalled report; the running-pointer add is the only slot-to-slot dependency.
// Reset:
//   rst (synchronous) empties both stages and clears the walk state, so a
//   walk without a begin starts from stack pointer zero.
// Back-pressure:
//   While report is stalled, slot transactions keep flowing; a finish waits
//   in the input stage and walk.ready drops until the report is taken.
// ----------------------------------------------------------------------------
module unwind_code_stack_walker_core import ucsw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ucsw_walk_if.sink     walk,
  ucsw_report_if.source report
);

  // input stage
  logic         stg_valid;
  walk_item_t   stg_item;
  logic         stg_advance;

  // walk state
  walk_state_t  state;
  walk_state_t  state_next;
  walk_report_t report_next;

  // output register
  logic         out_valid;
  walk_report_t out_data;
  logic         out_free;

  assign out_free    = !out_valid || report.ready;
  assign stg_advance = stg_valid && ((stg_item.action != ACT_FINISH) || out_free);
  assign walk.ready  = !stg_valid || stg_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (walk.ready) begin
      stg_valid <= walk.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (walk.valid && walk.ready) begin
      stg_item.action      <= walk.action;
      stg_item.slot_word   <= walk.slot_word;
      stg_item.start_rsp   <= walk.start_rsp;
      stg_item.func_offset <= walk.func_offset;
    end
  end

  ucsw_step u_step (
    .item   (stg_item),
    .cur    (state),
    .nxt    (state_next),
    .report (report_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (stg_advance) begin
      state <= state_next;
    end
  end

  // report register: loads on a finish leaving the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_advance && (stg_item.action == ACT_FINISH)) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_advance && (stg_item.action == ACT_FINISH)) begin
      out_data <= report_next;
    end
  end

  assign report.valid               = out_valid;
  assign report.return_slot_address = out_data.return_slot_address;
  assign report.caller_sp           = out_data.caller_sp;
  assign report.walk_status         = out_data.walk_status;

endmodule

### design/ucsw_step.sv
// ----------------------------------------------------------------------------
// ucsw_step
// Next-state and report logic for one walk item: slot decode, one 64-bit add for the next stack pointer.
// ----------------------------------------------------------------------------
module ucsw_step import ucsw_pkg::*; (
  input  walk_item_t   item,
  input  walk_state_t  cur,
  output walk_state_t  nxt,
  output walk_report_t report
);

  logic [31:0] addend;
  logic [63:0] sp_sum;
  logic        applies;
  logic [3:0]  op;
  logic [3:0]  info;
  logic [15:0] word;
  logic        op_err;

  assign word    = item.slot_word;
  assign op      = word[11:8];
  assign info    = word[15:12];
  assign applies = {24'd0, word[7:0]} <= cur.prolog;
  assign sp_sum  = cur.sp + {32'd0, addend};

  always_comb begin
    nxt    = cur;
    addend = '0;
    op_err = 1'b0;
    case (item.action)
      ACT_BEGIN: begin
        nxt        = '0;
        nxt.sp     = item.start_rsp;
        nxt.prolog = item.func_offset;
      end
      ACT_SLOT: begin
        if (cur.err == ST_OK) begin
          if (cur.slots_left != 2'd0) begin
            // operand slot
            case (cur.mode)
              MODE_SCALED: addend = {13'd0, word, 3'b000};
              MODE_RAW: begin
                if (cur.slots_left == 2'd2) nxt.low_half = word;
                else                        addend = {word, cur.low_half};
              end
              default: ;
            endcase
            nxt.slots_left = cur.slots_left - 2'd1;
            if (cur.slots_left == 2'd1) nxt.mode = MODE_SKIP;
          end else begin
            case (op)
              OP_PUSH_NONVOL: if (applies) addend = SLOT_BYTES;
              OP_ALLOC_LARGE: begin
                if (info == 4'd0) begin
                  nxt.slots_left = 2'd1;
                  nxt.mode       = applies ? MODE_SCALED : MODE_SKIP;
                end else begin
                  nxt.slots_left = 2'd2;
                  nxt.mode       = applies ? MODE_RAW : MODE_SKIP;
                end
              end
              OP_ALLOC_SMALL: if (applies) addend = {25'd0, info, 3'b000} + SLOT_BYTES;
              OP_SET_FPREG: ;
              OP_SAVE_NONVOL, OP_SAVE_XMM: begin
                nxt.slots_left = 2'd1;
                nxt.mode       = MODE_SKIP;
              end
              OP_SAVE_NONVOL_FAR, OP_SAVE_XMM_FAR: begin
                nxt.slots_left = 2'd2;
                nxt.mode       = MODE_SKIP;
              end
              OP_MACHFRAME: begin
                if (applies) begin
                  addend = (info == 4'd0) ? MACHFRAME_PLAIN : MACHFRAME_ERRCODE;
                  op_err = 1'b1;
                end
              end
              default: op_err = applies;
            endcase
          end
          nxt.sp = sp_sum;
          if (op_err) nxt.err = ST_NOT_IMPL;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    report.return_slot_address = cur.sp;
    report.caller_sp           = cur.sp + {32'd0, SLOT_BYTES};
    if (cur.err != ST_OK)              report.walk_status = cur.err;
    else if (cur.slots_left != 2'd0)   report.walk_status = ST_TRUNCATED;
    else                               report.walk_status = ST_OK;
  end

endmodule

### design/ucsw_checker.sv
// ----------------------------------------------------------------------------
// ucsw_checker
// Port-level checks on the stack walker, bound to the top level.
// ----------------------------------------------------------------------------
module ucsw_checker import ucsw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        walk_valid,
  input logic        walk_ready,
  input logic [1:0]  walk_action,
  input logic        report_valid,
  input logic        report_ready,
  input logic [63:0] report_return_slot_address,
  input logic [63:0] report_caller_sp,
  input logic [1:0]  report_walk_status
);

  // stalled report holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report_caller_sp))
    else $error("report dropped or changed while stalled");

  // caller sp is always the return slot plus one slot
  a_caller_sp: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report_caller_sp == report_return_slot_address + 64'd8)
    else $error("caller_sp inconsistent with return_slot_address");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report_walk_status != 2'd3)
    else $error("undefined walk status");

  // a fresh report traces back to an accepted finish, through the input stage and the report register
  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |->
      $past(walk_valid && walk_ready && (walk_action == ACT_FINISH), 2))
    else $error("report without a matching finish");

endmodule

bind unwind_code_stack_walker_core ucsw_checker u_ucsw_checker (
  .clk                        (clk),
  .rst                        (rst),
  .walk_valid                 (walk.valid),
  .walk_ready                 (walk.ready),
  .walk_action                (walk.action),
  .report_valid               (report.valid),
  .report_ready               (report.ready),
  .report_return_slot_address (report.return_slot_address),
  .report_caller_sp           (report.caller_sp),
  .report_walk_status         (report.walk_status)
);

### dv/unwind_code_stack_walker_core_tb.sv
// ----------------------------------------------------------------------------
// unwind_code_stack_walker_core_tb
// Self-checking bench for the unwind code stack walker. Items for the walk
// channel are queued up front (a directed opening, then random walks) and
// driven in random bursts. An in-bench model of the walk predicts every
// report, and the report channel is checked field by field against it
// while that channel stalls on its own pattern.
// ----------------------------------------------------------------------------
module unwind_code_stack_walker_core_tb import ucsw_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  // action code 3 has no meaning; the block drops it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned TOTAL_ITEMS   = 850;
  localparam int unsigned DRAIN_EVERY   = 250;
  localparam int unsigned SETTLE_CYCLES = 4;    // quiet cycles after a drain
  localparam int unsigned TAIL_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned MAX_SHOWN     = 10;

  typedef struct {
    walk_item_t item;
    bit         drain;   // hold the sender until all reports are back
  } pending_t;

  logic clk;
  logic rst;

  ucsw_walk_if   walk_ch ();
  ucsw_report_if report_ch ();

  unwind_code_stack_walker_core dut (
    .clk    (clk),
    .rst    (rst),
    .walk   (walk_ch),
    .report (report_ch)
  );

  pending_t     pending[$];
  walk_report_t expected_reports[$];
  walk_state_t  walk_st;           // predicted walk state
  int unsigned  item_count;        // items that the block acts on
  int unsigned  fail_count;
  int unsigned  cycle_count;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Walk prediction
  // ---------------------------------------------------------------------------
  // Operand slots that follow an op (unknown ops take none).
  function automatic int unsigned operand_slots(logic [3:0] op, logic [3:0] info);
    case (op)
      OP_ALLOC_LARGE:                      return (info == 4'd0) ? 1 : 2;
      OP_SAVE_NONVOL, OP_SAVE_XMM:         return 1;
      OP_SAVE_NONVOL_FAR, OP_SAVE_XMM_FAR: return 2;
      default:                             return 0;
    endcase
  endfunction

  // Advance the predicted walk by one accepted transaction; a finish
  // queues the report it must produce.
  task automatic apply_walk_item(input walk_item_t it);
    logic [7:0]   code_off;
    logic [3:0]   op;
    logic [3:0]   info;
    logic         applies;
    walk_report_t rep;
    code_off = it.slot_word[7:0];
    op       = it.slot_word[11:8];
    info     = it.slot_word[15:12];
    applies  = {24'd0, code_off} <= walk_st.prolog;
    case (it.action)
      ACT_BEGIN: begin
        walk_st        = '0;
        walk_st.sp     = it.start_rsp;
        walk_st.prolog = it.func_offset;
      end
      ACT_SLOT: begin
        // after an error the rest of the walk is dead
        if (walk_st.err == ST_OK) begin
          if (walk_st.slots_left != 2'd0) begin
            // operand slot of the previous op
            if (walk_st.mode == MODE_SCALED) begin
              walk_st.sp += {45'd0, it.slot_word, 3'd0};
            end else if (walk_st.mode == MODE_RAW) begin
              if (walk_st.slots_left == 2'd2) begin
                walk_st.low_half = it.slot_word;
              end else begin
                walk_st.sp += {32'd0, it.slot_word, walk_st.low_half};
              end
            end
            walk_st.slots_left -= 2'd1;
            if (walk_st.slots_left == 2'd0) walk_st.mode = MODE_SKIP;
          end else begin
            case (op)
              OP_PUSH_NONVOL: begin
                if (applies) walk_st.sp += 64'(SLOT_BYTES);
              end
              OP_ALLOC_LARGE: begin
                // size operands are consumed even when the op does not apply
                walk_st.slots_left = 2'(operand_slots(op, info));
                if (!applies) walk_st.mode = MODE_SKIP;
                else if (info == 4'd0) walk_st.mode = MODE_SCALED;
                else walk_st.mode = MODE_RAW;
              end
              OP_ALLOC_SMALL: begin
                if (applies) walk_st.sp += {57'd0, info, 3'd0} + 64'(SLOT_BYTES);
              end
              OP_SET_FPREG: ;
              OP_SAVE_NONVOL, OP_SAVE_XMM, OP_SAVE_NONVOL_FAR, OP_SAVE_XMM_FAR: begin
                walk_st.slots_left = 2'(operand_slots(op, info));
                walk_st.mode       = MODE_SKIP;
              end
              OP_MACHFRAME: begin
                if (applies) begin
                  walk_st.sp += (info == 4'd0) ? 64'(MACHFRAME_PLAIN)
                                               : 64'(MACHFRAME_ERRCODE);
                  walk_st.err = ST_NOT_IMPL;
                end
              end
              default: begin
                if (applies) walk_st.err = ST_NOT_IMPL;
              end
            endcase
          end
        end
      end
      ACT_FINISH: begin
        // state is kept, so a repeated finish reports the same again
        rep.return_slot_address = walk_st.sp;
        rep.caller_sp           = walk_st.sp + 64'(SLOT_BYTES);
        rep.walk_status         = walk_st.err;
        if (walk_st.err == ST_OK && walk_st.slots_left != 2'd0) begin
          rep.walk_status = ST_TRUNCATED;
        end
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] slot(logic [3:0] op, logic [3:0] info, logic [7:0] code);
    return {info, op, code};
  endfunction

  task automatic push_item(input logic [1:0] act, input logic [15:0] word,
                           input logic [63:0] rsp, input logic [31:0] off);
    pending_t p;
    p.item.action      = act;
    p.item.slot_word   = word;
    p.item.start_rsp   = rsp;
    p.item.func_offset = off;
    p.drain            = 1'b0;
    pending.push_back(p);
    if (act != ACT_UNUSED) item_count++;
  endtask

  // fields a transaction does not use still carry random bits
  task automatic push_slot(input logic [15:0] word);
    push_item(ACT_SLOT, word, rand64(), $urandom());
  endtask

  task automatic push_finish();
    push_item(ACT_FINISH, 16'($urandom()), rand64(), $urandom());
  endtask

  task automatic push_begin(input logic [63:0] rsp, input logic [31:0] off);
    push_item(ACT_BEGIN, 16'($urandom()), rsp, off);
  endtask

  task automatic push_drain();
    pending_t p;
    p.item  = '0;
    p.drain = 1'b1;
    pending.push_back(p);
  endtask

  task automatic build_directed();
    // slot and finish before any begin run on the reset state
    push_finish();
    push_slot(slot(OP_PUSH_NONVOL, 4'h0, 8'h00));
    push_item(ACT_UNUSED, 16'hFFFF, '1, '1);
    push_finish();
    // near the top of the address space: the running pointer wraps past zero
    push_begin(64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF);
    push_slot(slot(OP_PUSH_NONVOL, 4'hF, 8'hFF));
    push_slot(slot(OP_ALLOC_SMALL, 4'hF, 8'hFF));
    push_slot(slot(OP_ALLOC_LARGE, 4'h0, 8'h10));
    push_slot(16'hFFFF);
    push_slot(slot(OP_ALLOC_LARGE, 4'hF, 8'h00));
    push_slot(16'hFFFF);
    push_slot(16'hFFFF);
    push_slot(slot(OP_SET_FPREG, 4'h5, 8'h05));
    push_slot(slot(OP_SAVE_NONVOL, 4'h3, 8'h07));
    push_slot(16'h0000);
    push_slot(slot(OP_SAVE_XMM_FAR, 4'h6, 8'h08));
    push_slot(16'hA5A5);
    push_slot(16'h5A5A);
    push_finish();
    // large alloc beyond the instruction, cut off after its first operand
    push_begin(64'h0, 32'h0);
    push_slot(slot(OP_ALLOC_LARGE, 4'h2, 8'h01));
    push_slot(16'h1234);
    push_finish();
    // machine frame: adds the frame, then the walk is dead
    push_begin(64'h1000, 32'h10);
    push_slot(slot(OP_MACHFRAME, 4'h1, 8'h10));
    push_slot(slot(OP_PUSH_NONVOL, 4'h0, 8'h00));
    push_finish();
    push_finish();
  endtask

  function automatic logic [3:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_MACHFRAME;
    if (r < 5) return 4'($urandom());   // may be an unknown op
    case ($urandom_range(0, 7))
      0:       return OP_PUSH_NONVOL;
      1:       return OP_ALLOC_LARGE;
      2:       return OP_ALLOC_SMALL;
      3:       return OP_SET_FPREG;
      4:       return OP_SAVE_NONVOL;
      5:       return OP_SAVE_NONVOL_FAR;
      6:       return OP_SAVE_XMM;
      default: return OP_SAVE_XMM_FAR;
    endcase
  endfunction

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rand_rsp();
    case ($urandom_range(0, 6))
      0:       return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
      1:       return 64'($urandom_range(0, 4095));
      default: return rand64();
    endcase
  endfunction

  // Mix offsets inside and past the prolog so both sides of the
  // applies test get exercised.
  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 9))
      0, 1, 2:    return $urandom_range(0, 30);
      3, 4, 5, 6: return $urandom_range(0, 255);
      default:    return $urandom();
    endcase
  endfunction

  // One well-formed walk with random content, sometimes broken.
  task automatic gen_walk();
    int unsigned n_ops;
    int unsigned n_opnd;
    logic [3:0]  op;
    logic [3:0]  info;
    if ($urandom_range(0, 9) == 0) begin
      // noise: anything at all, unused action code included
      repeat ($urandom_range(1, 3)) push_item(2'($urandom()), 16'($urandom()),
                                              rand64(), $urandom());
    end
    push_begin(rand_rsp(), rand_offset());
    n_ops = $urandom_range(0, 10);
    for (int unsigned i = 0; i < n_ops; i++) begin
      op   = pick_op();
      info = ($urandom_range(0, 4) < 2) ? 4'd0 : 4'($urandom());
      push_slot(slot(op, info, 8'($urandom())));
      n_opnd = operand_slots(op, info);
      // now and then the walk ends inside the operands
      if (i == n_ops - 1 && n_opnd != 0 && $urandom_range(0, 9) == 0) begin
        n_opnd = $urandom_range(0, n_opnd - 1);
      end
      repeat (n_opnd) push_slot(rand_operand());
    end
    push_finish();
    if ($urandom_range(0, 9) == 0) push_finish();
    if ($urandom_range(0, 9) == 0) begin
      // the walk carries on after a finish
      repeat ($urandom_range(1, 3)) push_slot(16'($urandom()));
      push_finish();
    end
  endtask

  task automatic build_random();
    int unsigned next_drain;
    next_drain = item_count + DRAIN_EVERY;
    while (item_count < TOTAL_ITEMS) begin
      gen_walk();
      if (item_count >= next_drain) begin
        push_drain();
        next_drain += DRAIN_EVERY;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Walk driver: bursts of random length with random gaps; a drain marker
  // at the head of the queue holds the sender until all reports are in.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned settle_left;
  logic        drv_valid;
  pending_t    head;

  always @(posedge clk) begin
    if (rst) begin
      walk_ch.valid <= 1'b0;
      burst_left    = 0;
      gap_left      = 0;
      settle_left   = SETTLE_CYCLES;
    end else begin
      drv_valid = walk_ch.valid;
      if (walk_ch.valid && walk_ch.ready) begin
        head = pending.pop_front();
        apply_walk_item(head.item);
        drv_valid = 1'b0;
      end
      if (!drv_valid && pending.size() != 0) begin
        if (pending[0].drain) begin
          if (expected_reports.size() != 0) begin
            settle_left = SETTLE_CYCLES;
          end else if (settle_left != 0) begin
            settle_left--;
          end else begin
            pending.delete(0);
            settle_left = SETTLE_CYCLES;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          drv_valid = 1'b1;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9)
                                                     : $urandom_range(0, 2);
          end
        end
      end
      walk_ch.valid <= drv_valid;
      if (drv_valid) begin
        walk_ch.action      <= pending[0].item.action;
        walk_ch.slot_word   <= pending[0].item.slot_word;
        walk_ch.start_rsp   <= pending[0].item.start_rsp;
        walk_ch.func_offset <= pending[0].item.func_offset;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report stall pattern: open and stalled stretches of random length,
  // with an occasional long open stretch and an occasional long stall.
  // ---------------------------------------------------------------------------
  int unsigned rdy_left;
  logic        rdy_on;

  always @(posedge clk) begin
    if (rst) begin
      rdy_on          = 1'b0;
      rdy_left        = 0;
      report_ch.ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_on   = !rdy_on;
        if (rdy_on) begin
          rdy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 8);
        end else begin
          rdy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                 : $urandom_range(1, 3);
        end
      end else begin
        rdy_left--;
      end
      report_ch.ready <= rdy_on;
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: each report transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  walk_report_t got;
  walk_report_t want;

  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      got.return_slot_address = report_ch.return_slot_address;
      got.caller_sp           = report_ch.caller_sp;
      got.walk_status         = report_ch.walk_status;
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("%0t: report with none pending: ret %h caller %h status %0d",
                   $realtime, got.return_slot_address, got.caller_sp, got.walk_status);
        end
      end else begin
        want = expected_reports.pop_front();
        if (got.return_slot_address !== want.return_slot_address ||
            got.caller_sp !== want.caller_sp ||
            got.walk_status !== want.walk_status) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display({"%0t: report mismatch: ret exp %h got %h, ",
                      "caller exp %h got %h, status exp %0d got %0d"},
                     $realtime, want.return_slot_address, got.return_slot_address,
                     want.caller_sp, got.caller_sp, want.walk_status, got.walk_status);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    walk_ch.valid         = 1'b0;
    walk_ch.action        = ACT_BEGIN;
    walk_ch.slot_word     = '0;
    walk_ch.start_rsp     = '0;
    walk_ch.func_offset   = '0;
    report_ch.ready       = 1'b0;
    walk_st               = '0;    // matches the block after reset
    item_count            = 0;
    fail_count            = 0;
    cycle_count           = 0;

    build_directed();
    push_drain();                  // sender waits for every report here
    build_random();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || walk_ch.valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
